// ----- rtl/core/spike_reject_median_smoother_top_assert.svh -----
// Assertion macros for the spike reject median smoother top level.
`ifndef SPIKE_REJECT_MEDIAN_SMOOTHER_TOP_ASSERT_SVH
`define SPIKE_REJECT_MEDIAN_SMOOTHER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srms assertion failed");

// Next-cycle implication, checked out of reset.
`define SRMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srms assertion failed");

`endif

// ----- rtl/core/srms_pkg.sv -----
// Shared types and constants for the spike reject median smoother.
`default_nettype none
package srms_pkg;

  localparam int VAL_W = 15;

  localparam logic [VAL_W-1:0] SPIKE_LIMIT_RST = 15'd500;
  localparam logic [VAL_W-1:0] VAL_MAX         = 15'd32767;
  localparam int               MED_MIN_COUNT   = 3;
  localparam logic [15:0]      ROUND_BIAS      = 16'd5;
  localparam logic [15:0]      RECIP_10        = 16'd52429;
  localparam int               RECIP_SHIFT     = 19;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic scan;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/srms_cell.sv -----
// One window cell: holds a stored value and ranks it against a rotating probe.
`default_nettype none
module srms_cell #(
  parameter int CNT_W = 3
) (
  input  wire logic               clk,
  input  wire srms_pkg::cell_ctrl_t ctrl,
  input  wire logic               own_valid,
  input  wire srms_pkg::val_t     shift_in,
  input  wire srms_pkg::val_t     probe_in,
  input  wire logic               probe_vld_in,
  output srms_pkg::val_t          value_o,
  output srms_pkg::val_t          probe_o,
  output logic                    probe_vld_o,
  output logic [CNT_W-1:0]        less_o,
  output logic [CNT_W-1:0]        leq_o
);
  import srms_pkg::*;

  val_t             value_r;
  val_t             probe_r;
  logic             probe_vld_r;
  logic [CNT_W-1:0] less_r;
  logic [CNT_W-1:0] leq_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value_r <= shift_in;
    end
    if (ctrl.load) begin
      probe_r     <= value_r;
      probe_vld_r <= own_valid;
      less_r      <= '0;
      leq_r       <= '0;
    end else if (ctrl.scan) begin
      // count the probe against our value, then pass it on
      if (probe_vld_r) begin
        less_r <= less_r + CNT_W'(probe_r < value_r);
        leq_r  <= leq_r + CNT_W'(probe_r <= value_r);
      end
      probe_r     <= probe_in;
      probe_vld_r <= probe_vld_in;
    end
  end

  assign value_o     = value_r;
  assign probe_o     = probe_r;
  assign probe_vld_o = probe_vld_r;
  assign less_o      = less_r;
  assign leq_o       = leq_r;

endmodule
`default_nettype wire

// ----- rtl/core/srms_round.sv -----
// Rounds a median to the nearest multiple of ten, half up, with saturation.
`default_nettype none
module srms_round (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire srms_pkg::val_t med,
  output srms_pkg::val_t      result
);
  import srms_pkg::*;

  logic [31:0] prod_r;
  logic [12:0] quot;
  logic [16:0] times_ten;

  // divide by ten through the reciprocal, exact for every biased median
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= 32'({1'b0, med} + ROUND_BIAS) * 32'(RECIP_10);
    end
  end

  always_comb begin
    quot      = prod_r[31:RECIP_SHIFT];
    times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    if (times_ten > {2'b00, VAL_MAX}) begin
      result = VAL_MAX;
    end else begin
      result = times_ten[VAL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/spike_reject_median_smoother_top.sv -----
// Top level of the spike reject median smoother.
// Each request carries one distance estimate. A value of zero or less is
// returned unchanged. A positive value is ranked against the window by a
// ring of WINDOW_LEN cells: the values rotate once around the ring so that
// every cell learns the rank of its own value, and the cell holding the
// upper median supplies it. With three or more stored values the block runs
// this scan twice (spike check, then the smoothed output). The next request
// is taken while a finished result still waits in the output register.
// There is no clearing pass after reset.
`default_nettype none
module spike_reject_median_smoother_top #(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_raw_distance,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_distance_out,
  output logic                    out_spike_replaced,
  output logic                    out_smoothed_valid,
  input  wire logic               cfg_wr_en,
  input  wire logic [14:0]        cfg_wr_data
);
  import srms_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0] MIN_CNT   = CNT_W'(MED_MIN_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SCAN, ST_PICK, ST_CHECK, ST_INSERT, ST_MUL, ST_FIN, ST_OUT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   step_r;
  logic               phase_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  val_t               spike_limit_r;
  val_t               raw_r;
  val_t               val_r;
  val_t               med_r;
  logic signed [15:0] res_r;
  logic               spk_r;
  logic               sv_r;
  logic               out_valid_r;
  logic signed [15:0] out_dist_r;
  logic               out_spk_r;
  logic               out_sv_r;

  cell_ctrl_t         ctrl;
  logic               in_accept;
  logic               raw_pos;
  logic               is_spike;
  logic [CNT_W-1:0]   mid_rank;
  val_t               med_sel;
  val_t               rnd_result;

  val_t               cell_val   [WINDOW_LEN];
  val_t               cell_probe [WINDOW_LEN];
  logic               cell_pvld  [WINDOW_LEN];
  logic [CNT_W-1:0]   cell_less  [WINDOW_LEN];
  logic [CNT_W-1:0]   cell_leq   [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] cell_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign raw_pos   = !in_raw_distance[15] && (in_raw_distance != 16'sd0);
  assign count_nxt = (count_r < FULL_CNT) ? count_r + CNT_W'(1) : count_r;
  assign is_spike  = {1'b0, raw_r} > ({1'b0, med_r} + {1'b0, spike_limit_r});
  assign mid_rank  = count_r >> 1;

  always_comb begin
    ctrl       = '0;
    ctrl.shift = (state_r == ST_INSERT);
    ctrl.load  = (state_r == ST_LOAD);
    ctrl.scan  = (state_r == ST_SCAN);
  end

  // ring of cells, newest value in cell 0
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW_LEN - 1 : i - 1;
    assign cell_ok[i] = (CNT_W'(i) < count_r);

    srms_cell #(.CNT_W(CNT_W)) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .own_valid    (cell_ok[i]),
      .shift_in     ((i == 0) ? val_r : cell_val[PREV]),
      .probe_in     (cell_probe[PREV]),
      .probe_vld_in (cell_pvld[PREV]),
      .value_o      (cell_val[i]),
      .probe_o      (cell_probe[i]),
      .probe_vld_o  (cell_pvld[i]),
      .less_o       (cell_less[i]),
      .leq_o        (cell_leq[i])
    );
  end

  // every cell whose rank range covers the middle holds the same value
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (cell_ok[i] && (cell_less[i] <= mid_rank) && (mid_rank < cell_leq[i])) begin
        med_sel = med_sel | cell_val[i];
      end
    end
  end

  srms_round u_round (
    .clk    (clk),
    .load   (state_r == ST_MUL),
    .med    (med_r),
    .result (rnd_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      spike_limit_r <= SPIKE_LIMIT_RST;
      out_valid_r   <= 1'b0;
      step_r        <= '0;
      phase_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        spike_limit_r <= cfg_wr_data;
      end
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            raw_r <= in_raw_distance[VAL_W-1:0];
            if (!raw_pos) begin
              res_r   <= in_raw_distance;
              spk_r   <= 1'b0;
              sv_r    <= 1'b0;
              state_r <= ST_OUT;
            end else if (count_r >= MIN_CNT) begin
              phase_r <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              val_r   <= in_raw_distance[VAL_W-1:0];
              spk_r   <= 1'b0;
              state_r <= ST_INSERT;
            end
          end
        end
        ST_LOAD: begin
          step_r  <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          step_r <= step_r + CNT_W'(1);
          if (step_r == LAST_STEP) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          med_r   <= med_sel;
          state_r <= phase_r ? ST_MUL : ST_CHECK;
        end
        ST_CHECK: begin
          // replace a spike by the median before it enters the window
          spk_r   <= is_spike;
          val_r   <= is_spike ? med_r : raw_r;
          state_r <= ST_INSERT;
        end
        ST_INSERT: begin
          count_r <= count_nxt;
          if (count_nxt >= MIN_CNT) begin
            phase_r <= 1'b1;
            state_r <= ST_LOAD;
          end else begin
            res_r   <= {1'b0, val_r};
            spk_r   <= 1'b0;
            sv_r    <= 1'b0;
            state_r <= ST_OUT;
          end
        end
        ST_MUL: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          res_r   <= {1'b0, rnd_result};
          sv_r    <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= res_r;
            out_spk_r   <= spk_r;
            out_sv_r    <= sv_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distance_out   = out_dist_r;
  assign out_spike_replaced = out_spk_r;
  assign out_smoothed_valid = out_sv_r;

`include "spike_reject_median_smoother_top_assert.svh"

  `SRMS_ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && (step_r == LAST_STEP),
                    state_r == ST_PICK)
  `SRMS_ASSERT_NEXT(a_no_estimate_keeps_window, in_accept && !raw_pos,
                    $stable(count_r) && (state_r == ST_OUT))
  `SRMS_ASSERT_NOW(a_spike_needs_median, out_valid_r && out_spk_r, out_sv_r)
  `SRMS_ASSERT_NOW(a_median_needs_three, out_valid_r && out_sv_r, count_r >= MIN_CNT)

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for the spike reject median smoother: directed table, random phases, predictor check.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srms_pkg::*;

  localparam int WIN          = 5;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 88;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * WIN + 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PEND_DEPTH   = 16;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_RECEIVER_LIGHT,
    IDLE_NONE
  } idle_mode_t;

  typedef struct packed {
    logic signed [15:0] distance;
    logic               spike;
    logic               smooth;
  } smooth_result_t;

  typedef struct packed {
    logic signed [15:0] raw;
    logic               typed;
    smooth_result_t     res;
  } dir_row_t;

  localparam int NUM_DIR = 21;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_raw_distance;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_distance_out;
  logic               out_spike_replaced;
  logic               out_smoothed_valid;
  logic               cfg_wr_en;
  val_t               cfg_wr_data;

  // Rows with typed = 1 carry the result as it reads off directly.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{16'sd0,      1'b1, '{16'sd0,      1'b0, 1'b0}},
    '{-16'sd1,     1'b1, '{-16'sd1,     1'b0, 1'b0}},
    '{16'sh8000,   1'b1, '{16'sh8000,   1'b0, 1'b0}},
    '{16'sd32767,  1'b1, '{16'sd32767,  1'b0, 1'b0}},
    '{16'sd32767,  1'b1, '{16'sd32767,  1'b0, 1'b0}},
    '{16'sd32767,  1'b1, '{16'sd32767,  1'b0, 1'b1}},
    '{16'sd1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1,      1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1005,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd501,    1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd502,    1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1004,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1005,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1006,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1014,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd1015,   1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{-16'sd5,     1'b0, '{16'sd0,      1'b0, 1'b0}},
    '{16'sd32767,  1'b0, '{16'sd0,      1'b0, 1'b0}}
  };

  // Predictor state
  val_t limit_model;
  int   win_vals [WIN];
  int   win_fill;
  int   win_head;

  // Expected results in request order
  smooth_result_t pend_ring [PEND_DEPTH];
  int pend_wr        = 0;
  int pend_rd        = 0;
  int mismatch_count = 0;
  int snd_idle_pct   = 0;
  int rcv_idle_pct   = 0;
  int hold_requests  = 0;
  int cycle_cnt      = 0;

  spike_reject_median_smoother_top #(
    .WINDOW_LEN(WIN)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_distance    (in_raw_distance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distance_out   (out_distance_out),
    .out_spike_replaced (out_spike_replaced),
    .out_smoothed_valid (out_smoothed_valid),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int win_upper_median();
    int sorted [WIN];
    int i, j, v;
    for (i = 0; i < win_fill; i++) sorted[i] = win_vals[(win_head + i) % WIN];
    for (i = 1; i < win_fill; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[win_fill / 2];
  endfunction

  function automatic smooth_result_t predict_smoothed(input logic signed [15:0] raw);
    smooth_result_t r;
    int keep, med, rounded;
    r.distance = raw;
    r.spike    = 1'b0;
    r.smooth   = 1'b0;
    if (raw > 0) begin
      keep = raw;
      if (win_fill >= MED_MIN_COUNT) begin
        med = win_upper_median();
        if (longint'(raw) > longint'(med) + longint'(limit_model)) begin
          keep    = med;
          r.spike = 1'b1;
        end
      end
      if (win_fill < WIN) begin
        win_vals[(win_head + win_fill) % WIN] = keep;
        win_fill++;
      end else begin
        win_vals[win_head] = keep;
        win_head = (win_head + 1) % WIN;
      end
      if (win_fill >= MED_MIN_COUNT) begin
        rounded = ((win_upper_median() + 5) / 10) * 10;
        if (rounded > 32767) rounded = 32767;
        r.distance = 16'(rounded);
        r.smooth   = 1'b1;
      end else begin
        r.distance = 16'(keep);
        r.spike    = 1'b0;
      end
    end
    return r;
  endfunction

  // Mostly a noisy track around a center, with spikes, dropouts and raw noise.
  function automatic logic signed [15:0] pick_distance(input int center);
    int kind, v;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      v = center + int'($urandom_range(0, 400)) - 200;
      if (v < 1) v = 1;
      if (v > 32767) v = 32767;
    end else if (kind < 72) begin
      v = int'($urandom_range(center, 32767));
    end else if (kind < 82) begin
      v = -int'($urandom_range(0, 32768));
    end else if (kind < 88) begin
      case ($urandom_range(0, 3))
        0:       v = 1;
        1:       v = 32767;
        2:       v = 0;
        default: v = -32768;
      endcase
    end else begin
      v = $signed(16'($urandom));
    end
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    smooth_result_t want;
    if (pend_wr == pend_rd) begin
      report_mismatch("unexpected result distance_out", out_distance_out, 0);
      return;
    end
    want = pend_ring[pend_rd % PEND_DEPTH];
    pend_rd++;
    if (out_distance_out !== want.distance)
      report_mismatch("distance_out", out_distance_out, want.distance);
    if (out_spike_replaced !== want.spike)
      report_mismatch("spike_replaced", out_spike_replaced, want.spike);
    if (out_smoothed_valid !== want.smooth)
      report_mismatch("smoothed_valid", out_smoothed_valid, want.smooth);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        snd_idle_pct = 27;
        rcv_idle_pct = 54;
      end
      IDLE_RECEIVER_LIGHT: begin
        snd_idle_pct = 54;
        rcv_idle_pct = 27;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_distance(input logic signed [15:0] raw, input logic typed,
                               input smooth_result_t typed_res);
    smooth_result_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_raw_distance <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_smoothed(raw);
    pend_ring[pend_wr % PEND_DEPTH] = typed ? typed_res : pred;
    pend_wr++;
  endtask

  // Drop valid and hold until every request has produced its result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  task automatic write_spike_limit(input val_t value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_model = value;
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[spike_reject_median_smoother_top] ERROR");
    $finish;
  end

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result();
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  initial begin
    val_t limits [NUM_PHASES];
    int   ph, k, center;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_raw_distance <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    limit_model = SPIKE_LIMIT_RST;
    win_fill    = 0;
    win_head    = 0;
    limits[0] = '0;
    limits[1] = VAL_MAX;
    limits[2] = val_t'($urandom_range(0, 2000));
    limits[3] = SPIKE_LIMIT_RST;
    limits[4] = val_t'(1);
    limits[5] = val_t'($urandom_range(0, 32767));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(IDLE_SENDER_LIGHT);
    for (k = 0; k < NUM_DIR; k++)
      send_distance(dir_rows[k].raw, dir_rows[k].typed, dir_rows[k].res);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_spike_limit(limits[ph]);
      set_idle(idle_mode_t'(ph / 2));
      // Hold the receiver off so the block backs up into its input.
      if (ph == 4) hold_requests++;
      center = $urandom_range(50, 30000);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3) center = $urandom_range(50, 30000);
        send_distance(pick_distance(center), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[spike_reject_median_smoother_top] OK");
    end else begin
      $display("[spike_reject_median_smoother_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/srms_pkg.sv
rtl/core/srms_cell.sv
rtl/core/srms_round.sv
rtl/core/spike_reject_median_smoother_top.sv
bench/tb.sv
